// ----- hw/rtl/sfws_pkg.sv -----
// ----------------------------------------------------------------------------
// sfws_pkg
// Shared types and codes of the spi nor flash write sequencer.
// ----------------------------------------------------------------------------
package sfws_pkg;

    // request codes on the input tuser
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_SWRITE    = 3'd1;
    localparam logic [2:0] CMD_ERASE_SUB = 3'd2;
    localparam logic [2:0] CMD_ERASE_SEC = 3'd3;
    localparam logic [2:0] CMD_ERASE_CHP = 3'd4;
    localparam logic [2:0] CMD_READ_ID   = 3'd5;
    localparam logic [2:0] CMD_HOST_BYTE = 3'd6;
    localparam logic [2:0] CMD_SPI_RESP  = 3'd7;

    // result kinds on the output tuser
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_DATA    = 3'd2;
    localparam logic [2:0] KIND_ID      = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // flash opcodes
    localparam logic [7:0] OPC_RDSR  = 8'h05;
    localparam logic [7:0] OPC_WREN  = 8'h06;
    localparam logic [7:0] OPC_WRDI  = 8'h04;
    localparam logic [7:0] OPC_SSE   = 8'h20;
    localparam logic [7:0] OPC_SE    = 8'hD8;
    localparam logic [7:0] OPC_CE    = 8'hC7;
    localparam logic [7:0] OPC_RDID  = 8'h9F;
    localparam logic [7:0] OPC_READ  = 8'h03;
    localparam logic [7:0] OPC_PP    = 8'h02;
    localparam logic [7:0] ERASED    = 8'hFF;

    localparam int SECTOR_SHIFT = 16;
    localparam int MAX_RES      = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  mosi_byte;
        logic [7:0]  read_data;
        logic [23:0] device_id;
        logic        last;
    } result_t;

endpackage

// ----- hw/rtl/sfws_res_fifo.sv -----
// ----------------------------------------------------------------------------
// sfws_res_fifo
// Result queue: takes up to four results in one cycle, hands out one a cycle while the output is ready.
// ----------------------------------------------------------------------------
module sfws_res_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        push_cnt,
    input  sfws_pkg::result_t push_data [4],
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output sfws_pkg::result_t out_data
);
    import sfws_pkg::*;

    localparam int DEPTH = 8;

    result_t    fifo_mem [DEPTH];
    logic [2:0] wr_ptr_reg;
    logic [2:0] rd_ptr_reg;
    logic [3:0] count_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 4'd0);
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign room      = (count_reg <= 4'(DEPTH - MAX_RES));

    // storage of pushed results
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (3'(i) < push_cnt) begin
                fifo_mem[wr_ptr_reg + 3'(i)] <= push_data[i];
            end
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 3'd1;
            end
            count_reg <= count_reg + {1'b0, push_cnt} - {3'd0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 4'(DEPTH)) else $error("result queue overflow");
    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 3'd0 |-> $past(room)) else $error("push without room");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> rd_ptr_reg == $past(rd_ptr_reg) + 3'd1) else $error("pop lost");
`endif

endmodule

// ----- hw/rtl/spi_nor_flash_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// spi_nor_flash_write_sequencer
// SPI NOR flash command engine: read, read id, erases and a smart write that
// merges host bytes into a buffered subsector and erases only when needed.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  s_      | in        | tuser: cmd; tdata: address, block, length, host, miso
//  m_      | out       | tuser: kind; tdata: mosi, read data, device id
//
//  Each input transfer is first used to read the subsector buffer
//  (a 4096 x 8 synchronous memory); the registered item then works out the
//  results and writes the buffer back. Results (up to four) queue in an
//  eight-entry result queue; input is taken while four entries are free,
//  so a stalled output side only stops the input once more than four
//  results wait. No clearing pass after reset.
module spi_nor_flash_write_sequencer #(
    parameter int PAGE_BYTES      = 256,
    parameter int SUBSECTOR_BYTES = 4096,
    parameter int ADDRESS_BITS    = 26
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // byte_address, block_index, length, host_byte, miso_byte
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // mosi_byte, read_data, device_id
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import sfws_pkg::*;

    localparam int AW    = ADDRESS_BITS;
    localparam int OFF_W = $clog2(SUBSECTOR_BYTES);
    localparam int PG_W  = $clog2(PAGE_BYTES);
    localparam int PL_W  = PG_W + 1;
    localparam int CNT_W = $clog2(SUBSECTOR_BYTES + PAGE_BYTES + 8) + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RD_HDR, PH_RD_DATA, PH_ID, PH_SR_HDR, PH_SR_DATA, PH_HOST,
        PH_WREN, PH_POLL_CMD, PH_POLL_DAT, PH_OP, PH_WRDI
    } phase_t;
    typedef enum logic [2:0] {
        OP_ERASE_SUB, OP_ERASE_SEC, OP_ERASE_CHIP, OP_SW_ERASE, OP_PAGE
    } op_t;
    typedef enum logic [1:0] { AFTER_WREN, AFTER_OP, AFTER_WRDI } ctx_t;

    // state
    phase_t           phase_reg, phase_next;
    op_t              op_reg, op_next;
    ctx_t             ctx_reg, ctx_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    sub_base_reg, sub_base_next;
    logic [AW-1:0]    prog_addr_reg, prog_addr_next;
    logic [15:0]      total_reg, total_next;
    logic [CNT_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0] bcnt_reg, bcnt_next;
    logic [CNT_W-1:0] prog_left_reg, prog_left_next;
    logic [PL_W-1:0]  page_len_reg, page_len_next;
    logic             erase_reg, erase_next;
    logic [23:0]      id_reg, id_next;
    logic             busy_reg;

    // accepted item
    logic [2:0]       cmd_reg;
    logic [AW-1:0]    baddr_reg;
    logic [13:0]      blk_reg;
    logic [15:0]      len_reg;
    logic [7:0]       hb_reg;
    logic [7:0]       miso_reg;

    // subsector buffer
    logic [7:0]       buf_mem [SUBSECTOR_BYTES];
    logic [7:0]       buf_q;
    logic [OFF_W-1:0] rd_addr, rd_addr_reg;
    logic             buf_we;
    logic [OFF_W-1:0] buf_wa;
    logic [7:0]       buf_wd;

    // results
    result_t          res [4];
    logic [2:0]       res_cnt;
    logic             room;
    logic             accept;
    result_t          out_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg && room;

    function automatic logic [7:0] addr_byte(input logic [AW-1:0] a,
                                             input logic [CNT_W-1:0] k);
        logic [31:0] w;
        w = 32'(a);
        case (k)
            CNT_W'(1): addr_byte = w[31:24];
            CNT_W'(2): addr_byte = w[23:16];
            CNT_W'(3): addr_byte = w[15:8];
            default:   addr_byte = w[7:0];
        endcase
    endfunction

    function automatic result_t mk(input logic [2:0] kind, input logic [7:0] mosi,
                                   input logic [7:0] rd, input logic [23:0] id);
        result_t r;
        r.kind      = kind;
        r.mosi_byte = mosi;
        r.read_data = rd;
        r.device_id = id;
        r.last      = 1'b0;
        mk = r;
    endfunction

    // buffer address for the next item: host merge offset or program data byte
    always_comb begin
        if (phase_reg == PH_HOST) begin
            rd_addr = OFF_W'(cur_reg - sub_base_reg + AW'(bcnt_reg));
        end else begin
            rd_addr = OFF_W'(prog_addr_reg - sub_base_reg + AW'(bcnt_reg) - AW'(4));
        end
    end

    // buffer read and write
    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_q <= buf_mem[rd_addr];
        end
        if (buf_we) begin
            buf_mem[buf_wa] <= buf_wd;
        end
    end

    // command sequencing of each accepted item, done while busy
    always_comb begin
        logic          f_chunk_done;
        logic          f_start_chunk;
        logic          f_start_page;
        logic          f_start_op;
        logic          f_finish;
        op_t           f_op;
        logic [AW-1:0] opa;
        logic [CNT_W-1:0] optot;
        logic [7:0]    opb;

        phase_next     = phase_reg;
        op_next        = op_reg;
        ctx_next       = ctx_reg;
        cur_next       = cur_reg;
        sub_base_next  = sub_base_reg;
        prog_addr_next = prog_addr_reg;
        total_next     = total_reg;
        chunk_next     = chunk_reg;
        bcnt_next      = bcnt_reg;
        prog_left_next = prog_left_reg;
        page_len_next  = page_len_reg;
        erase_next     = erase_reg;
        id_next        = id_reg;
        buf_we         = 1'b0;
        buf_wa         = rd_addr_reg;
        buf_wd         = hb_reg;
        res_cnt        = '0;
        for (int i = 0; i < 4; i++) res[i] = mk(KIND_SEND, '0, '0, '0);
        f_chunk_done  = 1'b0;
        f_start_chunk = 1'b0;
        f_start_page  = 1'b0;
        f_start_op    = 1'b0;
        f_finish      = 1'b0;
        f_op          = OP_ERASE_SUB;
        opb           = '0;

        // operation address and length as seen by the op phase
        case (op_reg)
            OP_SW_ERASE: opa = sub_base_reg;
            OP_PAGE:     opa = prog_addr_reg;
            default:     opa = cur_reg;
        endcase
        if (op_reg == OP_ERASE_CHIP) optot = CNT_W'(1);
        else if (op_reg == OP_PAGE)  optot = CNT_W'(5) + CNT_W'(page_len_reg);
        else                         optot = CNT_W'(5);

        if (busy_reg) begin
            case (cmd_reg)
                CMD_READ, CMD_SWRITE, CMD_ERASE_SUB, CMD_ERASE_SEC, CMD_ERASE_CHP,
                CMD_READ_ID: begin
                    if (phase_reg != PH_IDLE) begin
                        res[res_cnt[1:0]] = mk(KIND_ERROR, '0, '0, '0);
                        res_cnt = res_cnt + 3'd1;
                    end else begin
                        case (cmd_reg)
                            CMD_READ: begin
                                cur_next = baddr_reg; total_next = len_reg;
                                bcnt_next = '0;
                                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_READ, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_RD_HDR;
                            end
                            CMD_SWRITE: begin
                                cur_next = baddr_reg; total_next = len_reg;
                                if (len_reg == 16'd0) f_finish = 1'b1;
                                else f_start_chunk = 1'b1;
                            end
                            CMD_ERASE_SUB: begin
                                cur_next = AW'({34'd0, blk_reg} << OFF_W);
                                f_start_op = 1'b1; f_op = OP_ERASE_SUB;
                            end
                            CMD_ERASE_SEC: begin
                                cur_next = AW'({34'd0, blk_reg} << SECTOR_SHIFT);
                                f_start_op = 1'b1; f_op = OP_ERASE_SEC;
                            end
                            CMD_ERASE_CHP: begin
                                f_start_op = 1'b1; f_op = OP_ERASE_CHIP;
                            end
                            default: begin
                                bcnt_next = '0; id_next = '0;
                                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_RDID, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_ID;
                            end
                        endcase
                    end
                end
                CMD_HOST_BYTE: begin
                    if (phase_reg != PH_HOST) begin
                        res[res_cnt[1:0]] = mk(KIND_ERROR, '0, '0, '0);
                        res_cnt = res_cnt + 3'd1;
                    end else begin
                        // merge host byte, note any byte that was not erased
                        if (buf_q != ERASED) erase_next = 1'b1;
                        buf_we = 1'b1;
                        bcnt_next = bcnt_reg + CNT_W'(1);
                        if (bcnt_next >= chunk_reg) begin
                            if (erase_next) begin
                                f_start_op = 1'b1; f_op = OP_SW_ERASE;
                            end else begin
                                prog_addr_next = cur_reg;
                                prog_left_next = chunk_reg;
                                f_start_page = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    case (phase_reg)
                        PH_RD_HDR, PH_SR_HDR: begin
                            bcnt_next = bcnt_reg + CNT_W'(1);
                            if (bcnt_next < CNT_W'(5)) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, addr_byte(
                                    (phase_reg == PH_RD_HDR) ? cur_reg : sub_base_reg,
                                    bcnt_next), '0, '0);
                                res_cnt = res_cnt + 3'd1;
                            end else if (phase_reg == PH_SR_HDR) begin
                                bcnt_next = '0;
                                res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_SR_DATA;
                            end else if (total_reg != 16'd0) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_RD_DATA;
                            end else begin
                                res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                f_finish = 1'b1;
                            end
                        end
                        PH_RD_DATA: begin
                            res[res_cnt[1:0]] = mk(KIND_DATA, '0, miso_reg, '0);
                            res_cnt = res_cnt + 3'd1;
                            total_next = total_reg - 16'd1;
                            if (total_next != 16'd0) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                            end else begin
                                res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                f_finish = 1'b1;
                            end
                        end
                        PH_SR_DATA: begin
                            buf_we = 1'b1;
                            buf_wa = OFF_W'(bcnt_reg);
                            buf_wd = miso_reg;
                            bcnt_next = bcnt_reg + CNT_W'(1);
                            if (bcnt_next < CNT_W'(SUBSECTOR_BYTES)) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                            end else begin
                                res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                bcnt_next = '0; erase_next = 1'b0;
                                phase_next = PH_HOST;
                            end
                        end
                        PH_ID: begin
                            if (bcnt_reg != '0) id_next = {id_reg[15:0], miso_reg};
                            bcnt_next = bcnt_reg + CNT_W'(1);
                            if (bcnt_next < CNT_W'(4)) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                            end else begin
                                res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                res[res_cnt[1:0]] = mk(KIND_ID, '0, '0, id_next);
                                res_cnt = res_cnt + 3'd1;
                                f_finish = 1'b1;
                            end
                        end
                        PH_WREN, PH_WRDI, PH_OP: begin
                            bcnt_next = bcnt_reg + CNT_W'(1);
                            if (phase_reg == PH_OP && bcnt_next < optot) begin
                                if (bcnt_next < CNT_W'(5)) opb = addr_byte(opa, bcnt_next);
                                else opb = buf_q;
                                res[res_cnt[1:0]] = mk(KIND_SEND, opb, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                            end else begin
                                // start status polling
                                if (phase_reg != PH_OP) bcnt_next = bcnt_reg;
                                res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_RDSR, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                if (phase_reg == PH_WREN) ctx_next = AFTER_WREN;
                                else if (phase_reg == PH_OP) ctx_next = AFTER_OP;
                                else ctx_next = AFTER_WRDI;
                                phase_next = PH_POLL_CMD;
                            end
                        end
                        PH_POLL_CMD: begin
                            res[res_cnt[1:0]] = mk(KIND_SEND, '0, '0, '0);
                            res_cnt = res_cnt + 3'd1;
                            phase_next = PH_POLL_DAT;
                        end
                        PH_POLL_DAT: begin
                            res[res_cnt[1:0]] = mk(KIND_RELEASE, '0, '0, '0);
                            res_cnt = res_cnt + 3'd1;
                            if (miso_reg[0]) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_RDSR, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_POLL_CMD;
                            end else if (ctx_reg == AFTER_WREN) begin
                                bcnt_next = '0;
                                case (op_reg)
                                    OP_ERASE_SEC:  opb = OPC_SE;
                                    OP_ERASE_CHIP: opb = OPC_CE;
                                    OP_PAGE:       opb = OPC_PP;
                                    default:       opb = OPC_SSE;
                                endcase
                                res[res_cnt[1:0]] = mk(KIND_SEND, opb, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_OP;
                            end else if (ctx_reg == AFTER_OP) begin
                                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_WRDI, '0, '0);
                                res_cnt = res_cnt + 3'd1;
                                phase_next = PH_WRDI;
                            end else if (op_reg == OP_SW_ERASE) begin
                                prog_addr_next = sub_base_reg;
                                prog_left_next = CNT_W'(SUBSECTOR_BYTES);
                                f_start_page = 1'b1;
                            end else if (op_reg == OP_PAGE) begin
                                prog_addr_next = prog_addr_reg + AW'(page_len_reg);
                                prog_left_next = prog_left_reg - CNT_W'(page_len_reg);
                                if (prog_left_next != '0) f_start_page = 1'b1;
                                else f_chunk_done = 1'b1;
                            end else begin
                                f_finish = 1'b1;
                            end
                        end
                        default: begin
                            res[res_cnt[1:0]] = mk(KIND_ERROR, '0, '0, '0);
                            res_cnt = res_cnt + 3'd1;
                        end
                    endcase
                end
            endcase

            // closing actions, in the order they chain
            if (f_chunk_done) begin
                total_next = total_reg - 16'(chunk_reg);
                cur_next   = cur_reg + AW'(chunk_reg);
                if (total_next == 16'd0) f_finish = 1'b1;
                else f_start_chunk = 1'b1;
            end
            if (f_start_chunk) begin
                sub_base_next = cur_next & ~AW'(SUBSECTOR_BYTES - 1);
                chunk_next = CNT_W'(SUBSECTOR_BYTES) - CNT_W'(cur_next[OFF_W-1:0]);
                if (32'(chunk_next) > 32'(total_next)) chunk_next = CNT_W'(total_next);
                bcnt_next = '0;
                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_READ, '0, '0);
                res_cnt = res_cnt + 3'd1;
                phase_next = PH_SR_HDR;
            end
            if (f_start_page) begin
                page_len_next = PL_W'(PAGE_BYTES) - PL_W'(prog_addr_next[PG_W-1:0]);
                if (CNT_W'(page_len_next) > prog_left_next) begin
                    page_len_next = PL_W'(prog_left_next);
                end
                f_start_op = 1'b1; f_op = OP_PAGE;
            end
            if (f_start_op) begin
                op_next = f_op;
                res[res_cnt[1:0]] = mk(KIND_SEND, OPC_WREN, '0, '0);
                res_cnt = res_cnt + 3'd1;
                phase_next = PH_WREN;
            end
            if (f_finish) begin
                res[res_cnt[1:0]] = mk(KIND_DONE, '0, '0, '0);
                res_cnt = res_cnt + 3'd1;
                phase_next = PH_IDLE;
            end
            if (res_cnt != 3'd0) res[2'(res_cnt - 3'd1)].last = 1'b1;
        end
    end

    // item capture and state registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= s_tuser;
            baddr_reg   <= AW'(s_tdata[25:0]);
            blk_reg     <= s_tdata[39:26];
            len_reg     <= s_tdata[55:40];
            hb_reg      <= s_tdata[63:56];
            miso_reg    <= s_tdata[71:64];
            rd_addr_reg <= rd_addr;
        end
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            op_reg        <= OP_ERASE_SUB;
            ctx_reg       <= AFTER_WREN;
            cur_reg       <= '0;
            sub_base_reg  <= '0;
            prog_addr_reg <= '0;
            total_reg     <= '0;
            chunk_reg     <= '0;
            bcnt_reg      <= '0;
            prog_left_reg <= '0;
            page_len_reg  <= '0;
            erase_reg     <= 1'b0;
            id_reg        <= '0;
        end else begin
            busy_reg      <= accept;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            ctx_reg       <= ctx_next;
            cur_reg       <= cur_next;
            sub_base_reg  <= sub_base_next;
            prog_addr_reg <= prog_addr_next;
            total_reg     <= total_next;
            chunk_reg     <= chunk_next;
            bcnt_reg      <= bcnt_next;
            prog_left_reg <= prog_left_next;
            page_len_reg  <= page_len_next;
            erase_reg     <= erase_next;
            id_reg        <= id_next;
        end
    end

    // result queue
    sfws_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (res_cnt),
        .push_data (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.device_id, out_res.read_data, out_res.mosi_byte};
    assign m_tlast = out_res.last;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && !s_tready) else $error("item not processed");
    a_result_per_item: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cmd_reg != CMD_HOST_BYTE |-> res_cnt != 3'd0)
        else $error("item without result");
    a_write_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_we |-> busy_reg) else $error("buffer write outside item");
`endif

endmodule
